FILE: rtl/core/olir_pkg.sv
`default_nettype none

package olir_pkg;

    localparam int VALUE_IN_W = 32;
    // step counter wide enough for log2 of the largest supported depth
    localparam int STEP_W = 4;

    localparam logic [1:0] CMD_INSERT       = 2'd0;
    localparam logic [1:0] CMD_REMOVE_RANGE = 2'd1;
    localparam logic [1:0] CMD_REMOVE_VALUE = 2'd2;

    typedef struct packed {
        logic [1:0]            command;
        logic [6:0]            position;
        logic [6:0]            length;
        logic [VALUE_IN_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [6:0] removed_count;
        logic       found;
        logic [5:0] match_index;
        logic [6:0] occupancy;
        logic       rejected;
    } rsp_t;

    typedef enum logic [2:0] {
        CELL_HOLD        = 3'd0,
        CELL_INSERT      = 3'd1,
        CELL_SHIFT       = 3'd2,
        CELL_SEARCH_INIT = 3'd3,
        CELL_SEARCH_STEP = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [STEP_W-1:0] step;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/olir_cell.sv
`default_nettype none

module olir_cell #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int INDEX       = 0,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int IW = $clog2(DEPTH),
    localparam int LG = $clog2(DEPTH)
) (
    input  wire logic                   clk,
    input  wire olir_pkg::cell_ctrl_t   ctrl,
    input  wire logic [CW-1:0]          pos,
    input  wire logic [CW-1:0]          used,
    input  wire logic [VALUE_WIDTH-1:0] val,
    input  wire logic [VALUE_WIDTH-1:0] left_data,
    input  wire logic [VALUE_WIDTH-1:0] right_data,
    input  wire logic [LG-1:0]          nb_vld,
    input  wire logic [IW-1:0]          nb_idx [LG],
    output logic [VALUE_WIDTH-1:0]      data,
    output logic                        best_vld,
    output logic [IW-1:0]               best_idx
);

    localparam int SW = olir_pkg::STEP_W;
    localparam logic [CW-1:0] MY_POS = CW'(INDEX);
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [VALUE_WIDTH-1:0] data_reg, data_next;
    logic                   best_vld_reg, best_vld_next;
    logic [IW-1:0]          best_idx_reg, best_idx_next;

    always_comb
    begin
        data_next     = data_reg;
        best_vld_next = best_vld_reg;
        best_idx_next = best_idx_reg;
        case (ctrl.op)
            olir_pkg::CELL_INSERT:
            begin
                if (MY_POS > pos)
                begin
                    data_next = left_data;
                end
                else if (MY_POS == pos)
                begin
                    data_next = val;
                end
            end
            olir_pkg::CELL_SHIFT:
            begin
                if (MY_POS >= pos)
                begin
                    data_next = right_data;
                end
            end
            olir_pkg::CELL_SEARCH_INIT:
            begin
                best_vld_next = (MY_POS < used) && (data_reg == val);
                best_idx_next = MY_IDX;
            end
            olir_pkg::CELL_SEARCH_STEP:
            begin
                // higher neighbor covers higher indices, so it wins
                for (int k = 0; k < LG; k++)
                begin
                    if ((ctrl.step == SW'(k)) && nb_vld[k])
                    begin
                        best_vld_next = 1'b1;
                        best_idx_next = nb_idx[k];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        best_vld_reg <= best_vld_next;
        best_idx_reg <= best_idx_next;
    end

    assign data     = data_reg;
    assign best_vld = best_vld_reg;
    assign best_idx = best_idx_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ordered_list_insert_remove.sv
`default_nettype none

// Ordered list of up to DEPTH values held in a chain of cells, one entry per
// cell. One request is worked at a time; req_stall is high from acceptance
// until the result is loaded into the output register, which can then wait
// on rsp_stall while the next request is taken. An insert is done in the
// execute state; a remove-range shifts the chain by the clipped length
// (the chain moves one place per cycle); a remove-value runs the last-match
// search, a log2(DEPTH)-step prefix pass through the cells, and on a match
// one shift closes the gap.
module ordered_list_insert_remove #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire olir_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output olir_pkg::rsp_t      rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int LG = $clog2(DEPTH);
    localparam int PW = (CW > 7) ? CW : 7;
    localparam int SW = olir_pkg::STEP_W;
    localparam int VI = olir_pkg::VALUE_IN_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_SEARCH = 6'b000100,
        ST_PICK   = 6'b001000,
        ST_SHIFT  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     used_reg, used_next;
    logic              rsp_valid_reg, rsp_valid_next;
    olir_pkg::req_t    req_reg, req_next;
    olir_pkg::rsp_t    rsp_reg, rsp_next;
    logic [SW-1:0]     step_reg, step_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     spos_reg, spos_next;
    logic [6:0]        rem_reg, rem_next;
    logic              found_reg, found_next;
    logic [5:0]        midx_reg, midx_next;
    logic              rej_reg, rej_next;

    logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
    logic                   cell_bvld [DEPTH];
    logic [IW-1:0]          cell_bidx [DEPTH];
    olir_pkg::cell_ctrl_t   cell_ctrl;
    logic [CW-1:0]          cell_pos;
    logic [VALUE_WIDTH-1:0] val_w;

    logic [PW-1:0] pos_e, used_e, len_e, room_e, clip_e;
    logic [CW-1:0] ins_pos;
    logic          full;

    if (VALUE_WIDTH > VI)
    begin : g_val_wide
        assign val_w = {{(VALUE_WIDTH - VI){1'b0}}, req_reg.value};
    end
    else
    begin : g_val_narrow
        assign val_w = req_reg.value[VALUE_WIDTH-1:0];
    end

    assign pos_e   = PW'(req_reg.position);
    assign used_e  = PW'(used_reg);
    assign len_e   = PW'(req_reg.length);
    assign room_e  = used_e - pos_e;
    assign clip_e  = (len_e > room_e) ? room_e : len_e;
    assign full    = (used_reg == CW'(DEPTH));
    assign ins_pos = (pos_e > used_e) ? used_reg : pos_e[CW-1:0];

    always_comb
    begin
        cell_ctrl.op   = olir_pkg::CELL_HOLD;
        cell_ctrl.step = step_reg;
        cell_pos       = spos_reg;
        case (state_reg)
            ST_EXEC:
            begin
                case (req_reg.command)
                    olir_pkg::CMD_INSERT:
                    begin
                        if (!full)
                        begin
                            cell_ctrl.op = olir_pkg::CELL_INSERT;
                            cell_pos     = ins_pos;
                        end
                    end
                    olir_pkg::CMD_REMOVE_VALUE:
                    begin
                        cell_ctrl.op = olir_pkg::CELL_SEARCH_INIT;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SEARCH:
            begin
                cell_ctrl.op = olir_pkg::CELL_SEARCH_STEP;
            end
            ST_SHIFT:
            begin
                cell_ctrl.op = olir_pkg::CELL_SHIFT;
            end
            default:
            begin
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_w;
        logic [VALUE_WIDTH-1:0] right_w;
        logic [LG-1:0]          nbv;
        logic [IW-1:0]          nbi [LG];

        if (i == 0)
        begin : g_first
            assign left_w = cell_data[i];
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        for (genvar k = 0; k < LG; k++)
        begin : g_nb
            if (i + (1 << k) < DEPTH)
            begin : g_link
                assign nbv[k] = cell_bvld[i + (1 << k)];
                assign nbi[k] = cell_bidx[i + (1 << k)];
            end
            else
            begin : g_edge
                assign nbv[k] = 1'b0;
                assign nbi[k] = '0;
            end
        end

        olir_cell #(
            .DEPTH       (DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .INDEX       (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .pos        (cell_pos),
            .used       (used_reg),
            .val        (val_w),
            .left_data  (left_w),
            .right_data (right_w),
            .nb_vld     (nbv),
            .nb_idx     (nbi),
            .data       (cell_data[i]),
            .best_vld   (cell_bvld[i]),
            .best_idx   (cell_bidx[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        rsp_valid_next = rsp_valid_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        spos_next      = spos_reg;
        rem_next       = rem_reg;
        found_next     = found_reg;
        midx_next      = midx_reg;
        rej_next       = rej_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                rem_next   = '0;
                found_next = 1'b0;
                midx_next  = '0;
                rej_next   = 1'b0;
                state_next = ST_FINISH;
                case (req_reg.command)
                    olir_pkg::CMD_INSERT:
                    begin
                        if (full)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            used_next = used_reg + CW'(1);
                        end
                    end
                    olir_pkg::CMD_REMOVE_RANGE:
                    begin
                        if ((pos_e < used_e) && (clip_e != '0))
                        begin
                            rem_next   = 7'(clip_e);
                            cnt_next   = clip_e[CW-1:0];
                            spos_next  = pos_e[CW-1:0];
                            state_next = ST_SHIFT;
                        end
                    end
                    olir_pkg::CMD_REMOVE_VALUE:
                    begin
                        step_next  = '0;
                        state_next = ST_SEARCH;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SEARCH:
            begin
                if (step_reg == SW'(LG - 1))
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    step_next = step_reg + SW'(1);
                end
            end
            ST_PICK:
            begin
                if (cell_bvld[0])
                begin
                    found_next = 1'b1;
                    rem_next   = 7'd1;
                    midx_next  = 6'(cell_bidx[0]);
                    spos_next  = CW'(cell_bidx[0]);
                    cnt_next   = CW'(1);
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT:
            begin
                used_next = used_reg - CW'(1);
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.removed_count = rem_reg;
                    rsp_next.found         = found_reg;
                    rsp_next.match_index   = midx_reg;
                    rsp_next.occupancy     = 7'(used_reg);
                    rsp_next.rejected      = rej_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        rsp_reg   <= rsp_next;
        step_reg  <= step_next;
        cnt_reg   <= cnt_next;
        spos_reg  <= spos_next;
        rem_reg   <= rem_next;
        found_reg <= found_next;
        midx_reg  <= midx_next;
        rej_reg   <= rej_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/core/olir_checker.sv
`default_nettype none

module olir_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire olir_pkg::req_t req,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire olir_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another is in progress");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.rejected |->
            rsp.removed_count == 7'd0 && !rsp.found && rsp.match_index == 6'd0)
        else $error("rejected insert reports a removal");

    a_found_one: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> rsp.removed_count == 7'd1)
        else $error("match found but removed count is not one");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.match_index == 6'd0)
        else $error("match index set without a match");

endmodule

bind ordered_list_insert_remove olir_checker u_olir_checker (.*);

`default_nettype wire
